>>> rtl/ntlm_single_block_hash_top_macros.svh
// assertion macros used by the rtl output buffer
`ifndef NTLM_SINGLE_BLOCK_HASH_TOP_MACROS_SVH
`define NTLM_SINGLE_BLOCK_HASH_TOP_MACROS_SVH

// same-cycle implication
`define NTLM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NTLM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ntlm_pkg.sv
`timescale 1ns / 1ps

package ntlm_pkg;

   typedef logic [31:0] word_type;

   typedef struct packed {
      word_type [3:0]  st;
      word_type [15:0] blk;
      logic            too_long;
   } ctx_type;

   localparam int unsigned NumSteps = 48;
   localparam logic [5:0]  MaxPwBytes = 6'd27;

   localparam word_type IV_A = 32'h67452301;
   localparam word_type IV_B = 32'hefcdab89;
   localparam word_type IV_C = 32'h98badcfe;
   localparam word_type IV_D = 32'h10325476;
   localparam word_type K_ROUND2 = 32'h5a827999;
   localparam word_type K_ROUND3 = 32'h6ed9eba1;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [1:0] ROUND_F = 2'd0;
   localparam logic [1:0] ROUND_G = 2'd1;
   localparam logic [1:0] ROUND_H = 2'd2;

   function automatic logic [3:0] msg_index(input logic [5:0] step);
      logic [3:0] j;
      logic [3:0] idx;
      j = step[3:0];
      case (step[5:4])
         ROUND_F: idx = j;
         ROUND_G: idx = {j[1:0], j[3:2]};
         default: idx = {j[0], j[1], j[2], j[3]};
      endcase
      return idx;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] step);
      logic [4:0] r;
      case ({step[5:4], step[1:0]})
         4'b0000: r = 5'd3;
         4'b0001: r = 5'd7;
         4'b0010: r = 5'd11;
         4'b0011: r = 5'd19;
         4'b0100: r = 5'd3;
         4'b0101: r = 5'd5;
         4'b0110: r = 5'd9;
         4'b0111: r = 5'd13;
         4'b1000: r = 5'd3;
         4'b1001: r = 5'd9;
         4'b1010: r = 5'd11;
         default: r = 5'd15;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/ntlm_single_block_hash_top.sv
// ntlm hash of one short password as a single md4 block, fully pipelined
// an accepted item passes the block build register, the 48 md4 step registers and the output buffer to rsp_valid
// throughput: one item per cycle while req_stall is low; each md4 step has its own pipeline stage
// req_stall rises only while the two-entry output buffer is full
// reset (synchronous) clears the valid bits of every stage and the output buffer
`timescale 1ns / 1ps

module ntlm_single_block_hash_top
   import ntlm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_chars_0_to_7,
   input  logic [63:0] req_chars_8_to_15,
   input  logic [63:0] req_chars_16_to_23,
   input  logic [63:0] req_chars_24_to_31,
   input  logic [5:0]  req_pw_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_a,
   output logic [31:0] rsp_digest_b,
   output logic [31:0] rsp_digest_c,
   output logic [31:0] rsp_digest_d,
   output logic        rsp_too_long
);

   logic    pipe_enable;
   logic    stg_valid [0:NumSteps];
   ctx_type stg_ctx   [0:NumSteps];

   assign req_stall = !pipe_enable;

   ntlm_msg_build u_build (
      .clock          (clock),
      .reset          (reset),
      .pipe_enable    (pipe_enable),
      .in_valid       (req_valid),
      .chars_0_to_7   (req_chars_0_to_7),
      .chars_8_to_15  (req_chars_8_to_15),
      .chars_16_to_23 (req_chars_16_to_23),
      .chars_24_to_31 (req_chars_24_to_31),
      .pw_length      (req_pw_length),
      .out_valid      (stg_valid[0]),
      .out_ctx        (stg_ctx[0])
   );

   for (genvar i = 0; i < NumSteps; i++) begin : g_step
      ntlm_md4_stage u_stage (
         .clock       (clock),
         .reset       (reset),
         .pipe_enable (pipe_enable),
         .step_idx    (6'(i)),
         .in_valid    (stg_valid[i]),
         .in_ctx      (stg_ctx[i]),
         .out_valid   (stg_valid[i+1]),
         .out_ctx     (stg_ctx[i+1])
      );
   end

   ntlm_out_buf u_out (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (stg_valid[NumSteps]),
      .in_ctx       (stg_ctx[NumSteps]),
      .pipe_enable  (pipe_enable),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_digest_a (rsp_digest_a),
      .rsp_digest_b (rsp_digest_b),
      .rsp_digest_c (rsp_digest_c),
      .rsp_digest_d (rsp_digest_d),
      .rsp_too_long (rsp_too_long)
   );

endmodule

>>> rtl/ntlm_msg_build.sv
`timescale 1ns / 1ps

module ntlm_msg_build
   import ntlm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        pipe_enable,
   input  logic        in_valid,
   input  logic [63:0] chars_0_to_7,
   input  logic [63:0] chars_8_to_15,
   input  logic [63:0] chars_16_to_23,
   input  logic [63:0] chars_24_to_31,
   input  logic [5:0]  pw_length,
   output logic        out_valid,
   output ctx_type     out_ctx
);

   logic    valid_ff;
   ctx_type ctx_ff;
   ctx_type ctx_in;

   always_comb begin
      logic [255:0] all_chars;
      logic [15:0]  unit;
      all_chars = {chars_24_to_31, chars_16_to_23, chars_8_to_15, chars_0_to_7};
      ctx_in = '0;
      ctx_in.st[0] = IV_A;
      ctx_in.st[1] = IV_B;
      ctx_in.st[2] = IV_C;
      ctx_in.st[3] = IV_D;
      // utf-16le units 0..27, pad byte right after the last one
      for (int k = 0; k < 28; k++) begin
         if (6'(k) < pw_length) begin
            unit = {8'd0, all_chars[8*k +: 8]};
         end else if (6'(k) == pw_length) begin
            unit = {8'd0, PAD_BYTE};
         end else begin
            unit = 16'd0;
         end
         ctx_in.blk[k/2][16*(k%2) +: 16] = unit;
      end
      ctx_in.blk[14] = {22'd0, pw_length, 4'd0};
      ctx_in.blk[15] = '0;
      ctx_in.too_long = (pw_length > MaxPwBytes);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         ctx_ff <= ctx_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctx   = ctx_ff;

endmodule

>>> rtl/ntlm_md4_stage.sv
`timescale 1ns / 1ps

module ntlm_md4_stage
   import ntlm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pipe_enable,
   input  logic [5:0] step_idx,
   input  logic       in_valid,
   input  ctx_type    in_ctx,
   output logic       out_valid,
   output ctx_type    out_ctx
);

   logic    valid_ff;
   ctx_type ctx_ff;
   ctx_type ctx_in;

   always_comb begin
      logic [1:0]  t;
      logic [1:0]  tx;
      logic [1:0]  ty;
      logic [1:0]  tz;
      word_type    x;
      word_type    y;
      word_type    z;
      word_type    f;
      word_type    kc;
      word_type    sum;
      logic [63:0] dbl;
      t  = 2'd0 - step_idx[1:0];
      tx = t + 2'd1;
      ty = t + 2'd2;
      tz = t + 2'd3;
      x  = in_ctx.st[tx];
      y  = in_ctx.st[ty];
      z  = in_ctx.st[tz];
      case (step_idx[5:4])
         ROUND_F: begin
            f  = z ^ (x & (y ^ z));
            kc = '0;
         end
         ROUND_G: begin
            f  = (x & (y | z)) | (y & z);
            kc = K_ROUND2;
         end
         default: begin
            f  = x ^ y ^ z;
            kc = K_ROUND3;
         end
      endcase
      sum = in_ctx.st[t] + f + in_ctx.blk[msg_index(step_idx)] + kc;
      dbl = {sum, sum} << rot_amount(step_idx);
      ctx_in = in_ctx;
      ctx_in.st[t] = dbl[63:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         ctx_ff <= ctx_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctx   = ctx_ff;

endmodule

>>> rtl/ntlm_out_buf.sv
`timescale 1ns / 1ps

module ntlm_out_buf
   import ntlm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  ctx_type  in_ctx,
   output logic     pipe_enable,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output word_type rsp_digest_a,
   output word_type rsp_digest_b,
   output word_type rsp_digest_c,
   output word_type rsp_digest_d,
   output logic     rsp_too_long
);

   `include "ntlm_single_block_hash_top_macros.svh"

   typedef struct packed {
      word_type [3:0] digest;
      logic           too_long;
   } result_type;

   logic       main_valid_ff;
   logic       skid_valid_ff;
   result_type main_ff;
   result_type skid_ff;
   result_type res_in;
   logic       push;
   logic       pop;

   always_comb begin
      res_in.too_long = in_ctx.too_long;
      if (in_ctx.too_long) begin
         res_in.digest = '0;
      end else begin
         res_in.digest[0] = in_ctx.st[0] + IV_A;
         res_in.digest[1] = in_ctx.st[1] + IV_B;
         res_in.digest[2] = in_ctx.st[2] + IV_C;
         res_in.digest[3] = in_ctx.st[3] + IV_D;
      end
   end

   assign pipe_enable = !skid_valid_ff;
   assign push        = pipe_enable && in_valid;
   assign pop         = main_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_ff <= res_in;
         end else begin
            main_ff <= res_in;
         end
      end
   end

   assign rsp_valid    = main_valid_ff;
   assign rsp_digest_a = main_ff.digest[0];
   assign rsp_digest_b = main_ff.digest[1];
   assign rsp_digest_c = main_ff.digest[2];
   assign rsp_digest_d = main_ff.digest[3];
   assign rsp_too_long = main_ff.too_long;

   `NTLM_ASSERT_NOW(a_skid_needs_main, skid_valid_ff, main_valid_ff,
      "skid entry without main entry")
   `NTLM_ASSERT_NEXT(a_push_to_skid, push && main_valid_ff && !pop, skid_valid_ff,
      "item pushed into full output stage was not kept")
   `NTLM_ASSERT_NOW(a_too_long_zero, main_valid_ff && main_ff.too_long,
      main_ff.digest == '0, "too_long item with nonzero digest")

endmodule

>>> dv/ntlm_hash_checker.sv
`timescale 1ns / 1ps

module ntlm_hash_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [63:0] req_chars_0_to_7,
   input  logic [63:0] req_chars_8_to_15,
   input  logic [63:0] req_chars_16_to_23,
   input  logic [63:0] req_chars_24_to_31,
   input  logic [5:0]  req_pw_length,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_digest_a,
   input  logic [31:0] rsp_digest_b,
   input  logic [31:0] rsp_digest_c,
   input  logic [31:0] rsp_digest_d,
   input  logic        rsp_too_long,
   output int          err_count,
   output int          pending_count
);

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic        too_long;
   } digest_type;

   localparam logic [5:0] MAX_LEN = 6'd27;
   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [31:0] ADD_G = 32'h5a827999;
   localparam logic [31:0] ADD_H = 32'h6ed9eba1;

   // message word used by each of the 48 steps
   localparam logic [0:47][3:0] WORD_ORDER =
      192'h0123456789abcdef_048c159d26ae37bf_084c2a6e195d3b7f;
   localparam logic [0:11][4:0] ROT_AMT = {
      5'd3, 5'd7, 5'd11, 5'd19,
      5'd3, 5'd5, 5'd9,  5'd13,
      5'd3, 5'd9, 5'd11, 5'd15
   };

   digest_type expected_digests[$];

   function automatic digest_type ntlm_digest(input logic [63:0] w0, input logic [63:0] w1,
                                              input logic [63:0] w2, input logic [63:0] w3,
                                              input logic [5:0] len);
      logic [255:0] chars;
      logic [511:0] blk;
      logic [31:0]  h [4];
      logic [31:0]  x, y, z, f, add, sum;
      logic [4:0]   rot;
      int           s, t, k;
      digest_type   res;
      res = '0;
      if (len > MAX_LEN) begin
         res.too_long = 1'b1;
         return res;
      end
      chars = {w3, w2, w1, w0};
      blk = '0;
      // each byte widens to a utf-16le unit
      for (k = 0; k < len; k++) begin
         blk[16*k +: 8] = chars[8*k +: 8];
      end
      blk[16*len +: 8] = 8'h80;
      blk[14*32 +: 32] = {22'd0, len, 4'd0};
      h[0] = INIT_A;
      h[1] = INIT_B;
      h[2] = INIT_C;
      h[3] = INIT_D;
      for (s = 0; s < 48; s++) begin
         t = (4 - (s % 4)) % 4;
         x = h[(t + 1) % 4];
         y = h[(t + 2) % 4];
         z = h[(t + 3) % 4];
         if (s < 16) begin
            f = (x & y) | (~x & z);
            add = '0;
         end else if (s < 32) begin
            f = (x & y) | (x & z) | (y & z);
            add = ADD_G;
         end else begin
            f = x ^ y ^ z;
            add = ADD_H;
         end
         sum = h[t] + f + blk[32*WORD_ORDER[s] +: 32] + add;
         rot = ROT_AMT[(s / 16) * 4 + (s % 4)];
         h[t] = (sum << rot) | (sum >> (6'd32 - rot));
      end
      res.a = h[0] + INIT_A;
      res.b = h[1] + INIT_B;
      res.c = h[2] + INIT_C;
      res.d = h[3] + INIT_D;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      digest_type exp_item;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_digests.push_back(ntlm_digest(req_chars_0_to_7, req_chars_8_to_15,
                                                   req_chars_16_to_23, req_chars_24_to_31,
                                                   req_pw_length));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_digests.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %h %h %h %h %b",
                        $time, rsp_digest_a, rsp_digest_b, rsp_digest_c, rsp_digest_d,
                        rsp_too_long);
               err_count++;
            end else begin
               exp_item = expected_digests.pop_front();
               check_field("digest_a", exp_item.a, rsp_digest_a);
               check_field("digest_b", exp_item.b, rsp_digest_b);
               check_field("digest_c", exp_item.c, rsp_digest_c);
               check_field("digest_d", exp_item.d, rsp_digest_d);
               check_field("too_long", {31'd0, exp_item.too_long}, {31'd0, rsp_too_long});
            end
         end
      end
      pending_count <= expected_digests.size();
   end

endmodule

>>> dv/ntlm_single_block_hash_top_tb.sv
`timescale 1ns / 1ps

module ntlm_single_block_hash_top_tb;

   localparam int NUM_RANDOM = 1730;
   localparam int QUIET_ITEMS = 400;
   localparam int PRESSURE_ITEM = 900;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_chars_0_to_7 = '0;
   logic [63:0] req_chars_8_to_15 = '0;
   logic [63:0] req_chars_16_to_23 = '0;
   logic [63:0] req_chars_24_to_31 = '0;
   logic [5:0]  req_pw_length = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_a;
   logic [31:0] rsp_digest_b;
   logic [31:0] rsp_digest_c;
   logic [31:0] rsp_digest_d;
   logic        rsp_too_long;

   logic idle_on = 1'b0;
   logic hold_ask = 1'b0;
   int   err_count;
   int   pending_count;
   int   quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ntlm_single_block_hash_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_chars_0_to_7   (req_chars_0_to_7),
      .req_chars_8_to_15  (req_chars_8_to_15),
      .req_chars_16_to_23 (req_chars_16_to_23),
      .req_chars_24_to_31 (req_chars_24_to_31),
      .req_pw_length      (req_pw_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_a       (rsp_digest_a),
      .rsp_digest_b       (rsp_digest_b),
      .rsp_digest_c       (rsp_digest_c),
      .rsp_digest_d       (rsp_digest_d),
      .rsp_too_long       (rsp_too_long)
   );

   ntlm_hash_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_chars_0_to_7   (req_chars_0_to_7),
      .req_chars_8_to_15  (req_chars_8_to_15),
      .req_chars_16_to_23 (req_chars_16_to_23),
      .req_chars_24_to_31 (req_chars_24_to_31),
      .req_pw_length      (req_pw_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_a       (rsp_digest_a),
      .rsp_digest_b       (rsp_digest_b),
      .rsp_digest_c       (rsp_digest_c),
      .rsp_digest_d       (rsp_digest_d),
      .rsp_too_long       (rsp_too_long),
      .err_count          (err_count),
      .pending_count      (pending_count)
   );

   task automatic send_password(input logic [63:0] w0, input logic [63:0] w1,
                                input logic [63:0] w2, input logic [63:0] w3,
                                input logic [5:0] len);
      req_valid <= 1'b1;
      req_chars_0_to_7 <= w0;
      req_chars_8_to_15 <= w1;
      req_chars_16_to_23 <= w2;
      req_chars_24_to_31 <= w3;
      req_pw_length <= len;
      do @(posedge clock); while (req_stall);
      // each cycle idles with the same odds
      if (idle_on) begin
         while ($urandom_range(99) < 27) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   function automatic logic [63:0] random_chars();
      logic [63:0] w;
      int          b;
      w = {$urandom, $urandom};
      // printable text now and then
      if ($urandom_range(3) == 0) begin
         for (b = 0; b < 8; b++) begin
            w[8*b +: 8] = 8'($urandom_range(32, 126));
         end
      end
      return w;
   endfunction

   initial begin
      logic [5:0] len;
      int         n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_password('0, '0, '0, '0, 6'd0);
      send_password('1, '1, '1, '1, 6'd0);
      send_password(64'hff, '0, '0, '0, 6'd1);
      send_password(64'h80, '1, '1, '1, 6'd1);
      send_password(64'h64726f7773736170, '0, '0, '0, 6'd8);
      send_password('1, '1, '1, '1, 6'd27);
      send_password('0, '0, '0, '0, 6'd27);
      send_password({8{8'h80}}, {8{8'h80}}, {8{8'h80}}, {8{8'h80}}, 6'd27);
      send_password(random_chars(), random_chars(), random_chars(), random_chars(), 6'd27);
      send_password(random_chars(), random_chars(), random_chars(), random_chars(), 6'd26);
      send_password(random_chars(), '1, '1, '1, 6'd7);
      send_password(random_chars(), random_chars(), '1, '1, 6'd15);
      send_password(random_chars(), random_chars(), '0, '0, 6'd16);
      send_password(random_chars(), random_chars(), random_chars(), '1, 6'd23);
      send_password(random_chars(), random_chars(), random_chars(), '0, 6'd24);
      send_password('1, '1, '1, '1, 6'd28);
      send_password('0, '0, '0, '0, 6'd28);
      send_password(random_chars(), random_chars(), random_chars(), random_chars(), 6'd32);
      send_password('1, '1, '1, '1, 6'd63);
      send_password(random_chars(), random_chars(), random_chars(), random_chars(), 6'd45);

      for (n = 0; n < NUM_RANDOM; n++) begin
         if (n == QUIET_ITEMS) begin
            idle_on <= 1'b1;
         end
         if (n == PRESSURE_ITEM) begin
            hold_ask <= 1'b1;
         end
         if ($urandom_range(99) < 10) begin
            len = 6'($urandom_range(28, 63));
         end else begin
            len = 6'($urandom_range(0, 27));
         end
         send_password(random_chars(), random_chars(), random_chars(), random_chars(), len);
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // receiver side, with one long hold-off to back up the pipeline
   initial begin
      logic hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ask && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < 27);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
